FILE: hw/rtl/smpm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Stick median pulse mapper package
// Shared widths, constants, register indexes and control structures.
// ============================================================================
package smpm_pkg;

   localparam int SAMPLE_W      = 12;
   localparam int PULSE_W       = 11;
   localparam int SPAN_W        = 9;
   localparam int NUM_W         = SAMPLE_W + SPAN_W;
   localparam int STEP_W        = $clog2(NUM_W + 1);
   localparam int BURST_LEN_DEF = 10;
   localparam int CSR_IDX_W     = 2;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 24;

   localparam logic [SPAN_W-1:0]  PULSE_SPAN = SPAN_W'(500);
   localparam logic [PULSE_W-1:0] PULSE_MIN  = PULSE_W'(1000);
   localparam logic [PULSE_W-1:0] PULSE_MID  = PULSE_W'(1500);
   localparam logic [PULSE_W-1:0] PULSE_MAX  = PULSE_W'(2000);
   localparam logic [PULSE_W:0]   PULSE_SUM  = (PULSE_W + 1)'(3000);

   localparam logic [SAMPLE_W-1:0] CAL_LOW_RST    = SAMPLE_W'(0);
   localparam logic [SAMPLE_W-1:0] CAL_CENTER_RST = SAMPLE_W'(2048);
   localparam logic [SAMPLE_W-1:0] CAL_HIGH_RST   = SAMPLE_W'(4095);

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_CENTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_HIGH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 2'd3;

   typedef struct packed {
      logic insert;
      logic shift;
      logic load_med;
      logic load_clamp;
      logic load_mul;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic shift_done;
      logic div_done;
      logic flat;
      logic rsp_busy;
   } status_type;

endpackage

FILE: hw/rtl/smpm_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// Stick median pulse mapper controller
// Sequences sample insertion, median selection, clamp, scale, divide and map.
// ============================================================================
module smpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  smpm_pkg::status_type status,
   output smpm_pkg::cmd_type    cmd
);
   import smpm_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_MED   = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_MAP   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.insert = 1'b1;
               if (req_tlast) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (status.shift_done) begin
               state_in = ST_MED;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         ST_MED: begin
            cmd.load_med = 1'b1;
            state_in     = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.load_clamp = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_mul = 1'b1;
            state_in     = status.flat ? ST_MAP : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_MAP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_MAP: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/smpm_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// Stick median pulse mapper datapath
// Sorted sample row, median pick, clamp, scale, serial divider and output.
// ============================================================================
module smpm_dp #(
   parameter int BURST_LEN = smpm_pkg::BURST_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [smpm_pkg::SAMPLE_W-1:0]       sample,
   input  logic                                final_req,
   input  logic                                csr_valid,
   input  logic [smpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smpm_pkg::SAMPLE_W-1:0]       csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [smpm_pkg::SAMPLE_W-1:0]       median,
   output logic [smpm_pkg::PULSE_W-1:0]        pulse_us,
   input  smpm_pkg::cmd_type                   cmd,
   output smpm_pkg::status_type                status
);
   import smpm_pkg::*;

   localparam int CNT_W = $clog2(BURST_LEN + 1);

   logic [SAMPLE_W-1:0] cal_low_ff, cal_center_ff, cal_high_ff;
   logic                invert_ff;

   logic [SAMPLE_W-1:0] row_ff [BURST_LEN];
   logic [SAMPLE_W-1:0] row_in [BURST_LEN];
   logic [BURST_LEN-1:0] le;
   logic [CNT_W-1:0]    fill_ff, fill_in, cnt_new, cnt_less;
   logic [CNT_W-1:0]    shifts_ff, shifts_in;
   logic                even_ff, even_in;

   logic [SAMPLE_W-1:0] med_ff;
   logic [SAMPLE_W:0]   pair_sum;
   logic [SAMPLE_W-1:0] med_in;
   logic [SAMPLE_W-1:0] top_cut, clamped;
   logic [SAMPLE_W-1:0] vc_ff;
   logic                lower_ff, flat_ff;

   logic [SAMPLE_W-1:0] diff, den_in;
   logic [SAMPLE_W-1:0] den_ff;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SAMPLE_W:0]   rem_sh;
   logic                ge;
   logic [STEP_W-1:0]   step_ff;

   logic [NUM_W:0]      pulse_sum;
   logic [PULSE_W-1:0]  pulse_pos;
   logic [PULSE_W:0]    pulse_fin;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_med_ff;
   logic [PULSE_W-1:0]  rsp_pulse_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff    <= CAL_LOW_RST;
         cal_center_ff <= CAL_CENTER_RST;
         cal_high_ff   <= CAL_HIGH_RST;
         invert_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAL_LOW:    cal_low_ff    <= csr_data;
            CSR_CAL_CENTER: cal_center_ff <= csr_data;
            CSR_CAL_HIGH:   cal_high_ff   <= csr_data;
            CSR_INVERT:     invert_ff     <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // The row stays sorted ascending: each new sample slides in behind all
   // stored entries that are not larger. Entries past the fill count are junk.
   always_comb begin
      for (int j = 0; j < BURST_LEN; j++) begin
         le[j] = (CNT_W'(j) < fill_ff) && (row_ff[j] <= sample);
      end
      for (int j = 0; j < BURST_LEN; j++) begin
         row_in[j] = row_ff[j];
         if (cmd.insert && (fill_ff != CNT_W'(BURST_LEN))) begin
            if (le[j]) begin
               row_in[j] = row_ff[j];
            end else if (j == 0) begin
               row_in[j] = sample;
            end else if (le[j-1]) begin
               row_in[j] = sample;
            end else begin
               row_in[j] = row_ff[j-1];
            end
         end else if (cmd.shift) begin
            if (j < BURST_LEN - 1) begin
               row_in[j] = row_ff[j+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < BURST_LEN; j++) begin
         row_ff[j] <= row_in[j];
      end
   end

   // Fill count and the number of shifts that bring the lower middle to entry 0.
   always_comb begin
      cnt_new   = (fill_ff != CNT_W'(BURST_LEN)) ? fill_ff + CNT_W'(1) : fill_ff;
      cnt_less  = cnt_new - CNT_W'(1);
      fill_in   = fill_ff;
      shifts_in = shifts_ff;
      even_in   = even_ff;
      if (cmd.insert) begin
         if (final_req) begin
            fill_in   = '0;
            shifts_in = cnt_less >> 1;
            even_in   = ~cnt_new[0];
         end else begin
            fill_in = cnt_new;
         end
      end else if (cmd.shift) begin
         shifts_in = shifts_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      shifts_ff <= shifts_in;
      even_ff   <= even_in;
   end

   // Median, then clamp and segment choice.
   assign pair_sum = {1'b0, row_ff[0]} + {1'b0, row_ff[1]};
   assign med_in   = even_ff ? pair_sum[SAMPLE_W:1] : row_ff[0];
   assign top_cut  = (med_ff > cal_high_ff) ? cal_high_ff : med_ff;
   assign clamped  = (top_cut < cal_low_ff) ? cal_low_ff : top_cut;

   always_ff @(posedge clock) begin
      if (cmd.load_med) begin
         med_ff <= med_in;
      end
      if (cmd.load_clamp) begin
         vc_ff    <= clamped;
         lower_ff <= clamped < cal_center_ff;
         flat_ff  <= !(clamped < cal_center_ff) && (cal_high_ff <= cal_center_ff);
      end
   end

   // Scale by the pulse span, then restoring division one quotient bit a cycle.
   assign diff   = lower_ff ? vc_ff - cal_low_ff : vc_ff - cal_center_ff;
   assign den_in = lower_ff ? cal_center_ff - cal_low_ff : cal_high_ff - cal_center_ff;
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      rem_in = ge ? SAMPLE_W'(rem_sh - {1'b0, den_ff}) : rem_sh[SAMPLE_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mul) begin
         quo_ff  <= NUM_W'(diff) * NUM_W'(PULSE_SPAN);
         den_ff  <= den_in;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Offset, saturation and mirroring.
   always_comb begin
      pulse_sum = {1'b0, quo_ff} + (NUM_W + 1)'(lower_ff ? PULSE_MIN : PULSE_MID);
      if (flat_ff || (pulse_sum > (NUM_W + 1)'(PULSE_MAX))) begin
         pulse_pos = PULSE_MAX;
      end else begin
         pulse_pos = pulse_sum[PULSE_W-1:0];
      end
      pulse_fin = invert_ff ? PULSE_SUM - {1'b0, pulse_pos} : {1'b0, pulse_pos};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_med_ff   <= med_ff;
         rsp_pulse_ff <= pulse_fin[PULSE_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign median     = rsp_med_ff;
   assign pulse_us   = rsp_pulse_ff;

   assign status.shift_done = (shifts_ff == '0);
   assign status.div_done   = (step_ff == STEP_W'(NUM_W));
   assign status.flat       = flat_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_tready;

endmodule

FILE: hw/rtl/stick_median_pulse_mapper.sv
`timescale 1ns / 1ps
// ============================================================================
// Stick median pulse mapper
// Median of a burst of stick ADC samples, clamped and mapped to a servo pulse.
// ============================================================================
// Usage:
//   The req channel carries one ADC sample per beat; tlast marks the last
//   sample of a burst. Non-final samples are taken one per cycle and slid
//   into a sorted row of up to BURST_LEN entries; extra samples are dropped.
//   After the final beat req_tready stays low while the block works: row
//   shifting, a median step, a clamp step, a scaling multiply, a serial
//   divider (21 quotient bits and a finishing step, skipped on the flat
//   upper segment) and a mapping step.
//   The rsp channel carries median and pulse_us from an output register.
//   While a result waits on a stalled receiver, samples of the next burst
//   are still taken; only the next result waits for the register to empty.
//   The csr channel is always ready and writes the calibration by index;
//   write it only while the block is idle. Reset restores the calibration
//   defaults and empties the sample row.
// ============================================================================
module stick_median_pulse_mapper #(
   parameter int BURST_LEN = smpm_pkg::BURST_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [smpm_pkg::REQ_DATA_W-1:0]      req_tdata,  // [11:0] sample
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [smpm_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [11:0] median, [22:12] pulse_us
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [smpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smpm_pkg::SAMPLE_W-1:0]        csr_data
);
   import smpm_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [SAMPLE_W-1:0] median;
   logic [PULSE_W-1:0]  pulse_us;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {(RSP_DATA_W - SAMPLE_W - PULSE_W)'(0), pulse_us, median};

   smpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smpm_dp #(
      .BURST_LEN (BURST_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .sample     (req_tdata[SAMPLE_W-1:0]),
      .final_req  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .median     (median),
      .pulse_us   (pulse_us),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
